@@ sv/bba_pkg.sv @@
// Shared types and fixed constants of the buddy block allocator.
// Used by every module of the block; depends on nothing else.
package bba_pkg;

  localparam int unsigned ORD_W   = 4;
  localparam int unsigned MAX_ORD = 15;

  // One tag per base block: used flag and the order of the block that starts here.
  typedef struct packed {
    logic             used;
    logic [ORD_W-1:0] ord;
  } tag_t;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_PTR  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ORDER,
    S_ASCAN,
    S_SPLIT,
    S_FWALK,
    S_MRD,
    S_MCHK
  } bba_state_e;

endpackage

@@ sv/bba_tag_ram.sv @@
// Tag store of the buddy block allocator: one write port, one registered read port.
// Depends on bba_pkg for the tag type.
module bba_tag_ram import bba_pkg::*; #(
  parameter int unsigned AW      = 8,
  parameter int unsigned TOP_ORD = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  tag_t          wdata_i,
  input  logic [AW-1:0] raddr_i,
  output tag_t          rdata_o
);

  localparam int unsigned DEPTH = 1 << AW;

  tag_t mem_q [DEPTH];
  tag_t rdata_q;
  logic head_valid_q;
  logic rd_head_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  // Only entry zero is ever read before it is written; until then it reads
  // as one free block of the top order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      rd_head_q    <= 1'b0;
    end else begin
      if (we_i && (waddr_i == '0)) begin
        head_valid_q <= 1'b1;
      end
      rd_head_q <= (raddr_i == '0) && !head_valid_q;
    end
  end

  assign rdata_o = rd_head_q ? tag_t'{used: 1'b0, ord: ORD_W'(TOP_ORD)} : rdata_q;

endmodule

@@ sv/bba_unit.sv @@
// Shared index and byte arithmetic of the buddy block allocator.
// Depends on bba_pkg for the order width.
module bba_unit import bba_pkg::*; #(
  parameter int unsigned CW         = 9,
  parameter int unsigned BW         = 13,
  parameter int unsigned BASE_BYTES = 16
) (
  input  logic [CW-1:0]    idx_i,
  input  logic [ORD_W-1:0] ord_i,
  input  logic [BW-1:0]    byte_i,
  output logic [CW-1:0]    sum_o,
  output logic [CW-1:0]    flip_o,
  output logic [CW-1:0]    clr_o,
  output logic [BW-1:0]    step_o,
  output logic [BW-1:0]    byte_sum_o
);

  logic [CW-1:0] bit_w;

  assign bit_w      = CW'(1) << ord_i;
  assign sum_o      = idx_i + bit_w;
  assign flip_o     = idx_i ^ bit_w;
  assign clr_o      = idx_i & ~bit_w;
  assign step_o     = BW'(BASE_BYTES) << ord_i;
  assign byte_sum_o = byte_i + step_o;

endmodule

@@ sv/buddy_block_allocator_top.sv @@
// Top level of the buddy block allocator: request sequencer, tag store and shared unit.
// Depends on bba_pkg, bba_tag_ram and bba_unit.

// Binary buddy allocator over a heap of HEAP_BYTES split into base blocks of
// BASE_BYTES. A request is taken when start_i is high while busy_o is low; busy_o
// then stays high until the request is finished (a free request with a zero
// pointer is refused without raising busy_o), and exactly one result appears for
// one cycle with done_o high. The receiver cannot stall, so the result must be
// captured in that cycle. An allocate request first steps the order up one per
// cycle, then scans the block heads in address order at one head per cycle, then
// writes one split half per cycle. A free request walks the block heads up to the
// pointer at one head per cycle, then passes through S_MRD and S_MCHK for each
// buddy merge: the buddy's head is read, then checked and the merged head written.
// These rates are set by the single read port of the tag store, whose read data
// is registered, and by the one shared index adder. The tag store needs no
// clearing pass after reset: only its first entry is read before being written,
// and a valid flag covers that entry. The heap must hold at least two base blocks.
module buddy_block_allocator_top import bba_pkg::*; #(
  parameter int unsigned HEAP_BYTES = 4096,
  parameter int unsigned BASE_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        op_i,
  input  logic [11:0] request_bytes_i,
  input  logic [11:0] pointer_offset_i,
  output logic        done_o,
  output logic [11:0] result_offset_o,
  output logic [1:0]  status_o
);

  // Top order is floor(log2(block count)), limited by the tag order field.
  localparam int unsigned NBLK    = HEAP_BYTES / BASE_BYTES;
  localparam int unsigned TOP_RAW = $clog2(NBLK + 1) - 1;
  localparam int unsigned TOP     = (TOP_RAW > MAX_ORD) ? MAX_ORD : TOP_RAW;
  localparam int unsigned IW      = (TOP > 0) ? TOP : 1;
  localparam int unsigned CW      = IW + 1;
  localparam int unsigned BW_RAW  = $clog2((BASE_BYTES << TOP) + 1);
  localparam int unsigned BW      = (BW_RAW > 13) ? BW_RAW : 13;
  localparam logic [ORD_W-1:0] TOP_ORD = ORD_W'(TOP);

  bba_state_e       state_q, state_d;
  logic [12:0]      need_q, need_d;
  logic [11:0]      addr_q, addr_d;
  logic [ORD_W-1:0] k_q, k_d;
  logic [ORD_W-1:0] ord_q, ord_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [BW-1:0]    byte_q, byte_d;
  logic             done_q, done_d;
  logic [11:0]      off_q, off_d;
  status_e          status_q, status_d;

  logic             ram_we;
  logic [IW-1:0]    ram_waddr;
  tag_t             ram_wdata;
  logic [IW-1:0]    ram_raddr;
  tag_t             ram_rdata;

  logic [CW-1:0]    u_idx;
  logic [ORD_W-1:0] u_ord;
  logic [BW-1:0]    u_byte;
  logic [CW-1:0]    u_sum;
  logic [CW-1:0]    u_flip;
  logic [CW-1:0]    u_clr;
  logic [BW-1:0]    u_step;
  logic [BW-1:0]    u_byte_sum;

  logic [ORD_W-1:0] ord_dec;
  logic [ORD_W-1:0] ord_inc;

  bba_tag_ram #(
    .AW      (IW),
    .TOP_ORD (TOP)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bba_unit #(
    .CW         (CW),
    .BW         (BW),
    .BASE_BYTES (BASE_BYTES)
  ) u_unit (
    .idx_i      (u_idx),
    .ord_i      (u_ord),
    .byte_i     (u_byte),
    .sum_o      (u_sum),
    .flip_o     (u_flip),
    .clr_o      (u_clr),
    .step_o     (u_step),
    .byte_sum_o (u_byte_sum)
  );

  assign ord_dec = ord_q - ORD_W'(1);
  assign ord_inc = ord_q + ORD_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      done_q   <= 1'b0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  // Payload and working registers carry no reset.
  always_ff @(posedge clk_i) begin
    need_q <= need_d;
    addr_q <= addr_d;
    k_q    <= k_d;
    ord_q  <= ord_d;
    idx_q  <= idx_d;
    byte_q <= byte_d;
    off_q  <= off_d;
  end

  always_comb begin
    state_d   = state_q;
    need_d    = need_q;
    addr_d    = addr_q;
    k_d       = k_q;
    ord_d     = ord_q;
    idx_d     = idx_q;
    byte_d    = byte_q;
    done_d    = 1'b0;
    off_d     = off_q;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q[IW-1:0];
    ram_wdata = tag_t'{used: 1'b0, ord: ord_q};
    ram_raddr = '0;
    u_idx     = idx_q;
    u_ord     = ord_q;
    u_byte    = byte_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          idx_d  = '0;
          byte_d = '0;
          if (op_e'(op_i) == OP_ALLOC) begin
            need_d  = {1'b0, request_bytes_i} + 13'd1;
            k_d     = '0;
            state_d = S_ORDER;
          end else if (pointer_offset_i == 12'd0) begin
            done_d   = 1'b1;
            off_d    = '0;
            status_d = ST_BAD_PTR;
          end else begin
            addr_d  = pointer_offset_i - 12'd1;
            state_d = S_FWALK;
          end
        end
      end

      // Smallest order whose block holds the request plus its header byte.
      S_ORDER: begin
        u_ord = k_q;
        if ((k_q < TOP_ORD) && (u_step < BW'(need_q))) begin
          k_d = k_q + ORD_W'(1);
        end else if (u_step < BW'(need_q)) begin
          done_d   = 1'b1;
          off_d    = '0;
          status_d = ST_NO_SPACE;
          state_d  = S_IDLE;
        end else begin
          state_d = S_ASCAN;
        end
      end

      // One block head per cycle; the next head's address goes out at once.
      S_ASCAN: begin
        u_ord = ram_rdata.ord;
        if (!ram_rdata.used && (ram_rdata.ord >= k_q)) begin
          ram_we    = 1'b1;
          ram_wdata = tag_t'{used: 1'b1, ord: k_q};
          off_d     = byte_q[11:0] + 12'd1;
          status_d  = ST_OK;
          if (ram_rdata.ord > k_q) begin
            ord_d   = ram_rdata.ord;
            state_d = S_SPLIT;
          end else begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        end else if (u_sum[IW]) begin
          done_d   = 1'b1;
          off_d    = '0;
          status_d = ST_NO_SPACE;
          state_d  = S_IDLE;
        end else begin
          idx_d     = u_sum;
          byte_d    = u_byte_sum;
          ram_raddr = u_sum[IW-1:0];
        end
      end

      // Mark the upper half free at each halving step.
      S_SPLIT: begin
        u_ord     = ord_dec;
        ram_we    = 1'b1;
        ram_waddr = u_sum[IW-1:0];
        ram_wdata = tag_t'{used: 1'b0, ord: ord_dec};
        ord_d     = ord_dec;
        if (ord_dec == k_q) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      // Walk the heads until the byte offset reaches the pointer's block.
      S_FWALK: begin
        u_ord = ram_rdata.ord;
        if (byte_q >= BW'(addr_q)) begin
          off_d = '0;
          if ((byte_q == BW'(addr_q)) && ram_rdata.used) begin
            ram_we    = 1'b1;
            ram_wdata = tag_t'{used: 1'b0, ord: ram_rdata.ord};
            ord_d     = ram_rdata.ord;
            status_d  = ST_OK;
            if (ram_rdata.ord < TOP_ORD) begin
              state_d = S_MRD;
            end else begin
              done_d  = 1'b1;
              state_d = S_IDLE;
            end
          end else begin
            done_d   = 1'b1;
            status_d = ST_BAD_PTR;
            state_d  = S_IDLE;
          end
        end else if (u_sum[IW]) begin
          done_d   = 1'b1;
          off_d    = '0;
          status_d = ST_BAD_PTR;
          state_d  = S_IDLE;
        end else begin
          idx_d     = u_sum;
          byte_d    = u_byte_sum;
          ram_raddr = u_sum[IW-1:0];
        end
      end

      S_MRD: begin
        ram_raddr = u_flip[IW-1:0];
        state_d   = S_MCHK;
      end

      // Merge while the buddy is a free block of the same order.
      S_MCHK: begin
        if (ram_rdata == tag_t'{used: 1'b0, ord: ord_q}) begin
          ram_we    = 1'b1;
          ram_waddr = u_clr[IW-1:0];
          ram_wdata = tag_t'{used: 1'b0, ord: ord_inc};
          idx_d     = u_clr;
          ord_d     = ord_inc;
          if (ord_inc < TOP_ORD) begin
            state_d = S_MRD;
          end else begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign result_offset_o = off_q;
  assign status_o        = status_q;

  // The tag store is only written while a request is being worked on.
  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q != S_IDLE))
    else $error("tag store written while idle");

  // A failed request never reports a nonzero offset (a successful free also returns zero, unchecked here).
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (result_offset_o == 12'd0))
    else $error("nonzero offset on failure");

  // Merging only runs below the top order.
  a_merge_ord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_MRD) || (state_q == S_MCHK)) |-> (ord_q < TOP_ORD))
    else $error("merge beyond top order");

  // A split always ends at the wanted order, never below it.
  a_split_ord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SPLIT) |-> (ord_q > k_q))
    else $error("split below wanted order");

endmodule
